[src/bpt_pkg.sv]
// ----------------------------------------------------------------------------
// bpt_pkg
// shared constants, command and status codes, and controller/datapath structs
// ----------------------------------------------------------------------------
`default_nettype none

package bpt_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_BITS  = 16;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_HAS   = 3'd1;
    localparam logic [2:0] CMD_FIND  = 3'd2;
    localparam logic [2:0] CMD_ALL   = 3'd3;
    localparam logic [2:0] CMD_RANGE = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BEYOND = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    localparam logic REG_CHUNK = 1'b0;
    localparam logic REG_MASK  = 1'b1;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel;
        logic save_a;
        logic emit_single;
        logic scan_start;
        logic scan_run;
        logic emit_final;
    } ctl_t;

    typedef struct packed {
        logic [2:0] in_cmd;
        logic [2:0] cmd;
        logic       div_done;
        logic       scan_done;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

[src/bpt_div.sv]
// ----------------------------------------------------------------------------
// bpt_div
// restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic [31:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic [16:0] diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        diff  = trial - {1'b0, den_reg};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = diff[15:0];
            quo_next = {quo_reg[30:0], 1'b1};
        end
        else
        begin
            rem_next = trial[15:0];
            quo_next = {quo_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= (divisor == 16'd0) ? 16'd1 : divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[src/bpt_dp.sv]
// ----------------------------------------------------------------------------
// bpt_dp
// datapath: key memory, valid bits, counters, bucket scan and result register
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_dp #(
    parameter int DEPTH = bpt_pkg::DEPTH_DEF,
    localparam int IW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bpt_pkg::ctl_t                 ctl,
    output bpt_pkg::sts_t                      sts,
    input  wire logic [2:0]                    command,
    input  wire logic [31:0]                   meters,
    input  wire logic [bpt_pkg::KEY_BITS-1:0]  site_key,
    input  wire logic [31:0]                   range_from,
    input  wire logic [31:0]                   range_to,
    input  wire logic [15:0]                   chunk_length,
    input  wire logic [bpt_pkg::KEY_BITS-1:0]  compare_mask,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic [1:0]                         status,
    output logic                               present,
    output logic [31:0]                        position_m,
    output logic [bpt_pkg::KEY_BITS-1:0]       site_out,
    output logic [CW-1:0]                      stored_count,
    output logic                               last_flag
);

    localparam int KB = bpt_pkg::KEY_BITS;

    logic [KB-1:0] key_mem [DEPTH];

    logic [2:0]       cmd_reg;
    logic [KB-1:0]    key_reg;
    logic [31:0]      from_reg;
    logic [31:0]      to_reg;
    logic [31:0]      qa_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [CW-1:0]    extent_reg;
    logic [CW-1:0]    total_reg, total_next;

    logic [IW-1:0]    ptr_reg;
    logic [IW-1:0]    hi_reg;
    logic             issue_on_reg;
    logic             rd_pend_reg;
    logic [IW-1:0]    rd_idx_reg;
    logic [KB-1:0]    rd_data_reg;
    logic             pend_valid_reg;
    logic [KB-1:0]    pend_key_reg;
    logic             found_reg;
    logic [31:0]      found_pos_reg;

    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic             present_reg;
    logic [31:0]      position_reg;
    logic [KB-1:0]    site_reg;
    logic [CW-1:0]    count_reg;
    logic             last_reg;

    logic [31:0]      dividend;
    logic             div_done;
    logic [31:0]      div_q;
    logic [15:0]      chunk_eff;

    logic [IW-1:0]    a_idx;
    logic             a_in;
    logic             add_now;
    logic             has_hit;
    logic [CW-1:0]    ext_cand;
    logic             is_find;
    logic             hit;
    logic             hold;
    logic             list_emit;
    logic             out_free;
    logic             scan_empty;
    logic [IW-1:0]    scan_lo;
    logic [IW-1:0]    scan_hi;

    assign chunk_eff = (chunk_length == 16'd0) ? 16'd1 : chunk_length;

    always_comb
    begin
        if (ctl.div_sel)
            dividend = to_reg;
        else if (command == bpt_pkg::CMD_RANGE)
            dividend = range_from;
        else
            dividend = meters;
    end

    bpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (dividend),
        .divisor  (chunk_length),
        .done     (div_done),
        .quotient (div_q)
    );

    // single-item commands work on the saved bucket
    assign a_idx   = qa_reg[IW-1:0];
    assign a_in    = qa_reg < 32'(DEPTH);
    assign add_now = ctl.emit_single && (cmd_reg == bpt_pkg::CMD_ADD) && a_in;
    assign has_hit = (qa_reg < 32'(extent_reg)) && valid_reg[a_idx];
    assign ext_cand = CW'(a_idx) + CW'(1);
    assign total_next = (add_now && !valid_reg[a_idx]) ? total_reg + CW'(1) : total_reg;

    // scan bounds
    always_comb
    begin
        if (cmd_reg == bpt_pkg::CMD_RANGE)
        begin
            scan_empty = !((from_reg <= to_reg) && (div_q < 32'(extent_reg)));
            scan_lo    = qa_reg[IW-1:0];
            scan_hi    = div_q[IW-1:0];
        end
        else
        begin
            scan_empty = (extent_reg == '0);
            scan_lo    = '0;
            scan_hi    = IW'(extent_reg - CW'(1));
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign is_find   = (cmd_reg == bpt_pkg::CMD_FIND);
    assign hit       = rd_pend_reg && valid_reg[rd_idx_reg]
                       && (!is_find || (((rd_data_reg ^ key_reg) & compare_mask) == '0));
    // a list hit pushes out the previous key, so it waits for the result register
    assign hold      = hit && !is_find && pend_valid_reg && !out_free;
    assign list_emit = ctl.scan_run && hit && !is_find && pend_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            extent_reg <= '0;
            total_reg  <= '0;
        end
        else if (add_now)
        begin
            valid_reg[a_idx] <= 1'b1;
            total_reg        <= total_next;
            if (ext_cand > extent_reg)
                extent_reg <= ext_cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_on_reg   <= 1'b0;
            rd_pend_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else if (ctl.load)
        begin
            issue_on_reg   <= 1'b0;
            rd_pend_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else if (ctl.scan_start)
        begin
            issue_on_reg <= !scan_empty;
            rd_pend_reg  <= 1'b0;
        end
        else if (ctl.scan_run && !hold)
        begin
            if (hit && is_find)
            begin
                found_reg    <= 1'b1;
                issue_on_reg <= 1'b0;
                rd_pend_reg  <= 1'b0;
            end
            else
            begin
                if (hit)
                    pend_valid_reg <= 1'b1;
                rd_pend_reg <= issue_on_reg;
                if (issue_on_reg && (ptr_reg == hi_reg))
                    issue_on_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= command;
            key_reg  <= site_key;
            from_reg <= range_from;
            to_reg   <= range_to;
        end
        if (ctl.save_a)
            qa_reg <= div_q;
        if (add_now)
            key_mem[a_idx] <= key_reg;
        if (ctl.scan_start)
        begin
            ptr_reg <= scan_lo;
            hi_reg  <= scan_hi;
        end
        else if (ctl.scan_run && !hold)
        begin
            if (hit && is_find)
                found_pos_reg <= 32'(rd_idx_reg) * 32'(chunk_eff);
            else
            begin
                if (hit)
                    pend_key_reg <= rd_data_reg;
                if (issue_on_reg)
                begin
                    rd_data_reg <= key_mem[ptr_reg];
                    rd_idx_reg  <= ptr_reg;
                    ptr_reg     <= ptr_reg + IW'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.emit_single || ctl.emit_final || list_emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit_single)
        begin
            present_reg  <= 1'b0;
            position_reg <= '0;
            site_reg     <= '0;
            count_reg    <= total_next;
            last_reg     <= 1'b1;
            case (cmd_reg)
                bpt_pkg::CMD_ADD:
                begin
                    status_reg <= a_in ? bpt_pkg::ST_OK : bpt_pkg::ST_BEYOND;
                end
                bpt_pkg::CMD_HAS:
                begin
                    status_reg  <= bpt_pkg::ST_OK;
                    present_reg <= has_hit;
                end
                default:
                begin
                    status_reg <= bpt_pkg::ST_EMPTY;
                end
            endcase
        end
        else if (list_emit)
        begin
            status_reg   <= bpt_pkg::ST_OK;
            present_reg  <= 1'b0;
            position_reg <= '0;
            site_reg     <= pend_key_reg;
            count_reg    <= total_reg;
            last_reg     <= 1'b0;
        end
        else if (ctl.emit_final)
        begin
            present_reg  <= 1'b0;
            count_reg    <= total_reg;
            last_reg     <= 1'b1;
            position_reg <= '0;
            site_reg     <= '0;
            if (is_find)
            begin
                status_reg <= found_reg ? bpt_pkg::ST_OK : bpt_pkg::ST_EMPTY;
                if (found_reg)
                    position_reg <= found_pos_reg;
            end
            else
            begin
                status_reg <= pend_valid_reg ? bpt_pkg::ST_OK : bpt_pkg::ST_EMPTY;
                if (pend_valid_reg)
                    site_reg <= pend_key_reg;
            end
        end
    end

    assign sts.in_cmd    = command;
    assign sts.cmd       = cmd_reg;
    assign sts.div_done  = div_done;
    assign sts.scan_done = !issue_on_reg && !rd_pend_reg;
    assign sts.out_free  = out_free;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign present      = present_reg;
    assign position_m   = position_reg;
    assign site_out     = site_reg;
    assign stored_count = count_reg;
    assign last_flag    = last_reg;

endmodule

`default_nettype wire

[src/bpt_ctrl.sv]
// ----------------------------------------------------------------------------
// bpt_ctrl
// command sequencer: division, single-result steps, bucket scan and final item
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire bpt_pkg::sts_t sts,
    output bpt_pkg::ctl_t      ctl
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV1  = 7'b0000010,
        S_DIV2  = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_SSTRT = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_FLUSH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    case (sts.in_cmd)
                        bpt_pkg::CMD_ADD, bpt_pkg::CMD_HAS, bpt_pkg::CMD_RANGE:
                        begin
                            ctl.div_start = 1'b1;
                            state_next    = S_DIV1;
                        end
                        bpt_pkg::CMD_FIND, bpt_pkg::CMD_ALL:
                        begin
                            state_next = S_SSTRT;
                        end
                        default:
                        begin
                            state_next = S_EXEC;
                        end
                    endcase
                end
            end
            S_DIV1:
            begin
                if (sts.div_done)
                begin
                    ctl.save_a = 1'b1;
                    if (sts.cmd == bpt_pkg::CMD_RANGE)
                    begin
                        ctl.div_start = 1'b1;
                        ctl.div_sel   = 1'b1;
                        state_next    = S_DIV2;
                    end
                    else
                        state_next = S_EXEC;
                end
            end
            S_DIV2:
            begin
                ctl.div_sel = 1'b1;
                if (sts.div_done)
                    state_next = S_SSTRT;
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    ctl.emit_single = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SSTRT:
            begin
                ctl.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = S_FLUSH;
                else
                    ctl.scan_run = 1'b1;
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    ctl.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

[src/bucketed_position_table.sv]
// ----------------------------------------------------------------------------
// bucketed_position_table
// site keys stored by position bucket, with add, has, find and list commands
// ----------------------------------------------------------------------------
// one item at a time; the next item is taken while the last result waits
// add, has: result follows the 32-step bucket divider
// find, list all: one key memory read per cycle while no list result waits
// list range: two divisions, then the scan
// reset clears valid bits, extent and entry count; key memory is not cleared
`default_nettype none

module bucketed_position_table #(
    parameter int DEPTH = bpt_pkg::DEPTH_DEF,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    command,
    input  wire logic [31:0]                   meters,
    input  wire logic [bpt_pkg::KEY_BITS-1:0]  site_key,
    input  wire logic [31:0]                   range_from,
    input  wire logic [31:0]                   range_to,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         status,
    output logic                               present,
    output logic [31:0]                        position_m,
    output logic [bpt_pkg::KEY_BITS-1:0]       site_out,
    output logic [CW-1:0]                      stored_count,
    output logic                               last_flag
);

    logic [15:0]                     chunk_reg;
    logic [bpt_pkg::KEY_BITS-1:0]    mask_reg;
    logic                            wr_en;
    bpt_pkg::ctl_t                   ctl;
    bpt_pkg::sts_t                   sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= 16'd1;
            mask_reg  <= '1;
        end
        else if (wr_en)
        begin
            if (paddr[2] == bpt_pkg::REG_CHUNK)
                chunk_reg <= pwdata[15:0];
            else
                mask_reg <= pwdata[bpt_pkg::KEY_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == bpt_pkg::REG_MASK) ? 32'(mask_reg) : 32'(chunk_reg);

    bpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    bpt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .command      (command),
        .meters       (meters),
        .site_key     (site_key),
        .range_from   (range_from),
        .range_to     (range_to),
        .chunk_length (chunk_reg),
        .compare_mask (mask_reg),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .status       (status),
        .present      (present),
        .position_m   (position_m),
        .site_out     (site_out),
        .stored_count (stored_count),
        .last_flag    (last_flag)
    );

endmodule

`default_nettype wire

[dv/bucketed_position_table_tb.sv]
// ----------------------------------------------------------------------------
// bucketed_position_table_tb
// drives add, has, find and list commands through the valid/stall port,
// predicts every result from a local copy of the table and checks each one
// in order; the chunk length and compare mask are changed between phases
// ----------------------------------------------------------------------------
module bucketed_position_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int CW = 7;

    typedef struct packed {
        logic [1:0]    status;
        logic          present;
        logic [31:0]   position_m;
        logic [15:0]   site_out;
        logic [CW-1:0] stored_count;
        logic          last_flag;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] command = '0;
    logic [31:0] meters = '0;
    logic [15:0] site_key = '0;
    logic [31:0] range_from = '0;
    logic [31:0] range_to = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic present;
    logic [31:0] position_m;
    logic [15:0] site_out;
    logic [CW-1:0] stored_count;
    logic last_flag;

    bucketed_position_table #(.DEPTH(DEPTH)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .meters(meters), .site_key(site_key),
        .range_from(range_from), .range_to(range_to),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .present(present), .position_m(position_m),
        .site_out(site_out), .stored_count(stored_count), .last_flag(last_flag)
    );

    // local copy of the table
    logic [15:0] shadow_keys [DEPTH];
    logic        shadow_valid [DEPTH];
    int unsigned shadow_extent;
    int unsigned shadow_total;
    logic [15:0] cur_chunk;
    logic [15:0] cur_mask;

    table_result_t expected_results [$];
    int mismatch_count = 0;
    int result_count = 0;
    int item_count = 0;
    int list_result_count = 0;
    bit idle_enable = 1'b1;
    int hold_cycles = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int unsigned bucket_of(logic [31:0] pos);
        int unsigned d;
        d = (cur_chunk == 0) ? 1 : cur_chunk;
        return pos / d;
    endfunction

    function automatic table_result_t make_result(logic [1:0] st, logic pr,
                                                  logic [31:0] pos, logic [15:0] key);
        table_result_t r;
        r.status = st;
        r.present = pr;
        r.position_m = pos;
        r.site_out = key;
        r.stored_count = shadow_total[CW-1:0];
        r.last_flag = 1'b0;
        return r;
    endfunction

    task automatic predict_table(logic [2:0] cmd, logic [31:0] m, logic [15:0] key,
                                 logic [31:0] lo, logic [31:0] hi);
        table_result_t found [$];
        int unsigned b;
        int unsigned lb;
        int unsigned hb;
        int unsigned d;
        table_result_t r;
        d = (cur_chunk == 0) ? 1 : cur_chunk;
        case (cmd)
            bpt_pkg::CMD_ADD:
            begin
                b = bucket_of(m);
                if (b >= DEPTH)
                    found.push_back(make_result(bpt_pkg::ST_BEYOND, 1'b0, '0, '0));
                else
                begin
                    shadow_keys[b] = key;
                    if (!shadow_valid[b])
                    begin
                        shadow_valid[b] = 1'b1;
                        shadow_total++;
                    end
                    if (b + 1 > shadow_extent)
                        shadow_extent = b + 1;
                    found.push_back(make_result(bpt_pkg::ST_OK, 1'b0, '0, '0));
                end
            end
            bpt_pkg::CMD_HAS:
            begin
                b = bucket_of(m);
                found.push_back(make_result(bpt_pkg::ST_OK,
                    (b < shadow_extent) ? shadow_valid[b] : 1'b0, '0, '0));
            end
            bpt_pkg::CMD_FIND:
            begin
                for (int i = 0; i < shadow_extent; i++)
                    if (shadow_valid[i] && ((shadow_keys[i] ^ key) & cur_mask) == 0)
                    begin
                        found.push_back(make_result(bpt_pkg::ST_OK, 1'b0,
                                                    32'(i * d), '0));
                        break;
                    end
                if (found.size() == 0)
                    found.push_back(make_result(bpt_pkg::ST_EMPTY, 1'b0, '0, '0));
            end
            bpt_pkg::CMD_ALL, bpt_pkg::CMD_RANGE:
            begin
                lb = 0;
                hb = shadow_extent;
                if (cmd == bpt_pkg::CMD_RANGE)
                begin
                    hb = bucket_of(hi);
                    lb = bucket_of(lo);
                    if (lo > hi || hb >= shadow_extent)
                        hb = 0;
                    else
                        hb = hb + 1;
                end
                for (int unsigned i = lb; i < hb && i < shadow_extent; i++)
                    if (shadow_valid[i])
                        found.push_back(make_result(bpt_pkg::ST_OK, 1'b0, '0,
                                                    shadow_keys[i]));
                list_result_count += found.size();
            end
            default:
                found.push_back(make_result(bpt_pkg::ST_EMPTY, 1'b0, '0, '0));
        endcase
        if (found.size() == 0)
            found.push_back(make_result(bpt_pkg::ST_EMPTY, 1'b0, '0, '0));
        r = found[$];
        r.last_flag = 1'b1;
        found[$] = r;
        foreach (found[i])
            expected_results.push_back(found[i]);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 result_count, what, got, want);
    endtask

    // result checker and receiver idling
    always @(posedge clk)
    begin
        table_result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 32'(status), 32'd0);
            else
            begin
                w = expected_results.pop_front();
                if (status !== w.status)
                    report_mismatch("status", 32'(status), 32'(w.status));
                if (present !== w.present)
                    report_mismatch("present", 32'(present), 32'(w.present));
                if (position_m !== w.position_m)
                    report_mismatch("position_m", position_m, w.position_m);
                if (site_out !== w.site_out)
                    report_mismatch("site_out", 32'(site_out), 32'(w.site_out));
                if (stored_count !== w.stored_count)
                    report_mismatch("stored_count", 32'(stored_count),
                                    32'(w.stored_count));
                if (last_flag !== w.last_flag)
                    report_mismatch("last_flag", 32'(last_flag), 32'(w.last_flag));
            end
            result_count++;
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= idle_enable && ($urandom_range(99) < 32);
    end

    task automatic send_item(logic [2:0] cmd, logic [31:0] m, logic [15:0] key,
                             logic [31:0] lo, logic [31:0] hi);
        @(negedge clk);
        while (idle_enable && $urandom_range(99) < 32)
            @(negedge clk);
        in_valid <= 1'b1;
        command <= cmd;
        meters <= m;
        site_key <= key;
        range_from <= lo;
        range_to <= hi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_table(cmd, m, key, lo, hi);
        item_count++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        // the table is idle once the last result is taken; this adds margin
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [15:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {16'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'(bpt_pkg::REG_CHUNK * 4))
            cur_chunk = value;
        else
            cur_mask = value;
    endtask

    task automatic set_config(logic [15:0] chunk, logic [15:0] mask);
        wait_drained();
        write_reg(3'(bpt_pkg::REG_CHUNK * 4), chunk);
        write_reg(3'(bpt_pkg::REG_MASK * 4), mask);
    endtask

    // weighted random item: mostly adds and lookups near the table
    task automatic random_item(int unsigned span);
        logic [2:0] cmd;
        logic [31:0] m, lo, hi;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) cmd = bpt_pkg::CMD_ADD;
        else if (pick < 58) cmd = bpt_pkg::CMD_HAS;
        else if (pick < 73) cmd = bpt_pkg::CMD_FIND;
        else if (pick < 80) cmd = bpt_pkg::CMD_ALL;
        else if (pick < 95) cmd = bpt_pkg::CMD_RANGE;
        else cmd = 3'($urandom_range(7));
        m = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(span);
        lo = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(span);
        hi = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(span);
        send_item(cmd, m, 16'($urandom()), lo, hi);
    endtask

    task automatic test_directed();
        set_config(16'd1, 16'hFFFF);
        send_item(bpt_pkg::CMD_ALL, 0, '0, 0, 0);
        send_item(bpt_pkg::CMD_FIND, 0, 16'h1234, 0, 0);
        send_item(bpt_pkg::CMD_HAS, 0, '0, 0, 0);
        send_item(bpt_pkg::CMD_RANGE, 0, '0, 0, 0);
        send_item(bpt_pkg::CMD_ADD, 0, 16'hFFFF, 0, 0);
        send_item(bpt_pkg::CMD_ADD, 63, 16'h0000, 0, 0);
        send_item(bpt_pkg::CMD_ADD, 64, 16'hAAAA, 0, 0);
        send_item(bpt_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'h5555, 0, 0);
        send_item(bpt_pkg::CMD_ADD, 0, 16'h1234, 0, 0);
        send_item(bpt_pkg::CMD_ADD, 10, 16'h1234, 0, 0);
        send_item(bpt_pkg::CMD_HAS, 10, '0, 0, 0);
        send_item(bpt_pkg::CMD_HAS, 11, '0, 0, 0);
        send_item(bpt_pkg::CMD_HAS, 32'hFFFF_FFFF, '0, 0, 0);
        send_item(bpt_pkg::CMD_FIND, 0, 16'h1234, 0, 0);
        send_item(bpt_pkg::CMD_FIND, 0, 16'h0000, 0, 0);
        send_item(bpt_pkg::CMD_FIND, 0, 16'h4321, 0, 0);
        send_item(bpt_pkg::CMD_ALL, 0, '0, 0, 0);
        send_item(bpt_pkg::CMD_RANGE, 0, '0, 5, 63);
        send_item(bpt_pkg::CMD_RANGE, 0, '0, 20, 5);
        send_item(bpt_pkg::CMD_RANGE, 0, '0, 0, 64);
        send_item(bpt_pkg::CMD_RANGE, 0, '0, 11, 12);
        send_item(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(3'd7, 0, '0, 0, 0);
        set_config(16'd0, 16'h00F0);
        send_item(bpt_pkg::CMD_FIND, 0, 16'h0030, 0, 0);
        send_item(bpt_pkg::CMD_HAS, 63, '0, 0, 0);
    endtask

    task automatic test_random_chunks();
        set_config(16'd7, 16'hFFFF);
        repeat (140) random_item(7 * 70);
        set_config(16'hFFFF, 16'h0F0F);
        repeat (60) random_item(32'hFFFF * 70);
        set_config(16'd3, 16'h0000);
        repeat (100) random_item(3 * 70);
    endtask

    task automatic test_backpressure();
        set_config(16'd1, 16'hFF00);
        hold_cycles = 600;
        repeat (30) random_item(70);
    endtask

    task automatic test_no_idle();
        set_config(16'd2, 16'hFFFF);
        idle_enable = 1'b0;
        repeat (120) random_item(2 * 70);
        idle_enable = 1'b1;
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_keys[i] = '0;
            shadow_valid[i] = 1'b0;
        end
        shadow_extent = 0;
        shadow_total = 0;
        cur_chunk = 16'd1;
        cur_mask = 16'hFFFF;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_chunks();
        test_backpressure();
        test_no_idle();
        wait_drained();
        $display("covered %0d items and %0d results, %0d of them list keys",
                 item_count, result_count, list_result_count);
        $display("chunk lengths 0, 1, 2, 3, 7 and 65535 with several compare masks");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
